// ----- hw/rtl/ppft_pkg.sv -----
`timescale 1ns / 1ps

package ppft_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COORD_W    = 32;

  // Opcodes of a command transaction.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEAD_DIST   = 2'd0;
  localparam logic [1:0] CFG_TIME_AHEAD  = 2'd1;
  localparam logic [1:0] CFG_POINT_COUNT = 2'd2;

  localparam logic [30:0] LEAD_DIST_RST   = 31'd65536;
  localparam logic [30:0] TIME_AHEAD_RST  = 31'd65536;
  localparam logic [6:0]  POINT_COUNT_RST = 7'd2;

  typedef struct packed {
    logic                      opcode;
    logic [ADDR_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] nearest_x;
    logic signed [COORD_W-1:0] nearest_y;
    logic [ADDR_W-1:0]         nearest_segment;
    logic signed [COORD_W-1:0] future_x;
    logic signed [COORD_W-1:0] future_y;
  } res_t;

  // Clamp a wide intermediate to the coordinate range.
  function automatic logic signed [31:0] sat_coord(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Magnitude of a difference of two coordinates; it always fits 32 bits.
  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m[31:0];
  endfunction

endpackage

// ----- hw/rtl/polyline_path_follow_target_unit.sv -----
`timescale 1ns / 1ps

// Path follower target unit. A load transaction writes one path vertex. A
// query transaction predicts the future position, finds the closest point
// on the path and walks ahead by the configured lead distance to the target,
// or to the last vertex if the path ends first; the result appears for one
// cycle on res_o with res_valid_o and must be taken then. The search and the
// walk use the shared bit-serial square root for the segment lengths and the
// shared restoring divider for the unit components, both fed from the single
// vertex memory port. busy stays high from the query to its result.
module polyline_path_follow_target_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ppft_pkg::cmd_t   cmd_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  output logic             res_valid_o,
  output ppft_pkg::res_t   res_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FUT    = 5'd1;
  localparam logic [4:0] S_RD_S   = 5'd2;
  localparam logic [4:0] S_RD_E   = 5'd3;
  localparam logic [4:0] S_RD_X   = 5'd4;
  localparam logic [4:0] S_SQA    = 5'd5;
  localparam logic [4:0] S_SQB    = 5'd6;
  localparam logic [4:0] S_SQRT   = 5'd7;
  localparam logic [4:0] S_DXI    = 5'd8;
  localparam logic [4:0] S_DIVX   = 5'd9;
  localparam logic [4:0] S_DYI    = 5'd10;
  localparam logic [4:0] S_DIVY   = 5'd11;
  localparam logic [4:0] S_PJA    = 5'd12;
  localparam logic [4:0] S_PJB    = 5'd13;
  localparam logic [4:0] S_PTA    = 5'd14;
  localparam logic [4:0] S_PTB    = 5'd15;
  localparam logic [4:0] S_DSA    = 5'd16;
  localparam logic [4:0] S_DSB    = 5'd17;
  localparam logic [4:0] S_WINIT  = 5'd18;
  localparam logic [4:0] S_WCHK   = 5'd19;
  localparam logic [4:0] S_WLAST  = 5'd20;
  localparam logic [4:0] S_WLASTC = 5'd21;
  localparam logic [4:0] S_TGA    = 5'd22;
  localparam logic [4:0] S_TGB    = 5'd23;
  localparam logic [4:0] S_DONE   = 5'd24;

  logic [4:0] state_q, state_d;

  logic [30:0] la_q, ta_q;
  logic [6:0]  pc_q;

  logic [63:0] path_mem [ppft_pkg::MAX_POINTS];
  logic [63:0] rdata_q;
  logic [5:0]  raddr;

  ppft_pkg::cmd_t     cmd_q;
  logic signed [31:0] fx_q, fy_q, sx_q, sy_q, ex_q, ey_q;
  logic signed [31:0] qx_q, qy_q, nx_q, ny_q, tx_q, ty_q;
  logic signed [32:0] dx_q, dy_q;
  logic [65:0]        acc_q, best_d_q;
  logic [35:0]        rem_q;
  logic [32:0]        len_q;
  logic [5:0]         cnt_q, ptr_q, best_q;
  logic [47:0]        drem_q;
  logic [48:0]        dv_q;
  logic [16:0]        dq_q;
  logic signed [17:0] ux_q, uy_q;
  logic signed [51:0] pacc_q;
  logic signed [35:0] proj_q;
  logic [30:0]        total_q;
  logic               walk_q;

  logic               accept, load_we;
  logic [6:0]         n_w;
  logic               seg_more;
  logic [37:0]        rem_sh, trial;
  logic               sq_ge;
  logic [35:0]        rem_n;
  logic [32:0]        root_n;
  logic               dv_ge;
  logic [16:0]        dq_n;
  logic signed [17:0] unit_n;
  logic               div_neg;
  logic signed [63:0] fut_px, fut_py;
  logic signed [32:0] dfx, dfy;
  logic signed [50:0] pj_x, pj_y;
  logic signed [51:0] pj_sum;
  logic signed [51:0] pt_x, pt_y;
  logic [30:0]        rest;
  logic signed [49:0] tg_x, tg_y;
  logic [31:0]        m_a, m_b;
  logic [63:0]        sq_prod;
  logic [65:0]        dist_n;
  logic               go_on;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign load_we     = accept && (cmd_i.opcode == ppft_pkg::OP_LOAD);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (pc_q < 7'd2) begin
      n_w = 7'd2;
    end else if (pc_q > 7'(ppft_pkg::MAX_POINTS)) begin
      n_w = 7'(ppft_pkg::MAX_POINTS);
    end else begin
      n_w = pc_q;
    end
  end

  // Another segment follows the one at ptr_q when ptr_q + 2 < n.
  assign seg_more = ({1'b0, ptr_q} + 7'd2) < n_w;

  // One digit of the square root per cycle.
  assign rem_sh = {rem_q, acc_q[65:64]};
  assign trial  = {3'b000, len_q, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign rem_n  = sq_ge ? 36'(rem_sh - trial) : rem_sh[35:0];
  assign root_n = {len_q[31:0], sq_ge};

  // One quotient bit per cycle.
  assign dv_ge   = {1'b0, drem_q} >= dv_q;
  assign dq_n    = {dq_q[15:0], dv_ge};
  assign div_neg = (state_q == S_DIVX) ? dx_q[32] : dy_q[32];
  always_comb begin
    if (len_q == '0) begin
      unit_n = '0;
    end else if (div_neg) begin
      unit_n = -$signed({1'b0, dq_n});
    end else begin
      unit_n = $signed({1'b0, dq_n});
    end
  end

  assign fut_px = cmd_q.vel_x * $signed({1'b0, ta_q});
  assign fut_py = cmd_q.vel_y * $signed({1'b0, ta_q});
  assign dfx    = $signed({fx_q[31], fx_q}) - $signed({sx_q[31], sx_q});
  assign dfy    = $signed({fy_q[31], fy_q}) - $signed({sy_q[31], sy_q});
  assign pj_x   = dfx * ux_q;
  assign pj_y   = dfy * uy_q;
  assign pj_sum = pacc_q + 52'(pj_y);
  assign pt_x   = ux_q * $signed(proj_q[33:0]);
  assign pt_y   = uy_q * $signed(proj_q[33:0]);
  assign rest   = la_q - total_q;
  assign tg_x   = ux_q * $signed({1'b0, rest});
  assign tg_y   = uy_q * $signed({1'b0, rest});

  // One squaring unit, shared by the length and the distance steps.
  always_comb begin
    case (state_q)
      S_SQA:   m_a = ppft_pkg::mag33(dx_q);
      S_SQB:   m_a = ppft_pkg::mag33(dy_q);
      S_DSA:   m_a = ppft_pkg::mag33($signed({qx_q[31], qx_q}) - $signed({fx_q[31], fx_q}));
      S_DSB:   m_a = ppft_pkg::mag33($signed({qy_q[31], qy_q}) - $signed({fy_q[31], fy_q}));
      default: m_a = '0;
    endcase
    m_b = m_a;
  end
  assign sq_prod = m_a * m_b;
  assign dist_n  = acc_q + {2'b00, sq_prod};

  assign go_on = ({3'b000, total_q} + {1'b0, len_q}) < {3'b000, la_q};

  always_comb begin
    case (state_q)
      S_RD_E:  raddr = ptr_q + 6'd1;
      S_WINIT: raddr = best_q + 6'd1;
      S_WLAST: raddr = 6'(n_w - 7'd1);
      default: raddr = ptr_q;
    endcase
  end

  // Only one transaction is in flight and loads land while idle, so no read
  // whose data is used meets a write to the same entry.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      path_mem[cmd_i.vertex_index] <= {cmd_i.coord_x, cmd_i.coord_y};
    end
    rdata_q <= path_mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept && cmd_i.opcode == ppft_pkg::OP_QUERY) state_d = S_FUT;
      S_FUT:    state_d = S_RD_S;
      S_RD_S:   state_d = S_RD_E;
      S_RD_E:   state_d = S_RD_X;
      S_RD_X:   state_d = S_SQA;
      S_SQA:    state_d = S_SQB;
      S_SQB:    state_d = S_SQRT;
      S_SQRT:   if (cnt_q == 6'd32) state_d = walk_q ? S_WCHK : S_DXI;
      S_DXI:    state_d = S_DIVX;
      S_DIVX:   if (cnt_q == 6'd16) state_d = S_DYI;
      S_DYI:    state_d = S_DIVY;
      S_DIVY:   if (cnt_q == 6'd16) state_d = walk_q ? S_TGA : S_PJA;
      S_PJA:    state_d = S_PJB;
      S_PJB:    state_d = S_PTA;
      S_PTA: begin
        if (proj_q > $signed({3'b000, len_q}) || proj_q[35]) begin
          state_d = S_DSA;
        end else begin
          state_d = S_PTB;
        end
      end
      S_PTB:    state_d = S_DSA;
      S_DSA:    state_d = S_DSB;
      S_DSB:    state_d = seg_more ? S_RD_S : S_WINIT;
      S_WINIT:  state_d = S_RD_X;
      S_WCHK: begin
        if (!go_on) begin
          state_d = S_DXI;
        end else if (seg_more) begin
          state_d = S_RD_S;
        end else begin
          state_d = S_WLAST;
        end
      end
      S_WLAST:  state_d = S_WLASTC;
      S_WLASTC: state_d = S_DONE;
      S_TGA:    state_d = S_TGB;
      S_TGB:    state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      la_q    <= ppft_pkg::LEAD_DIST_RST;
      ta_q    <= ppft_pkg::TIME_AHEAD_RST;
      pc_q    <= ppft_pkg::POINT_COUNT_RST;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ppft_pkg::CFG_LEAD_DIST:   la_q <= cfg_data_i[30:0];
          ppft_pkg::CFG_TIME_AHEAD:  ta_q <= cfg_data_i[30:0];
          ppft_pkg::CFG_POINT_COUNT: pc_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) cmd_q <= cmd_i;
      end
      S_FUT: begin
        fx_q   <= ppft_pkg::sat_coord($signed({{18{cmd_q.coord_x[31]}}, cmd_q.coord_x})
                  + $signed({{2{fut_px[63]}}, fut_px[63:16]}));
        fy_q   <= ppft_pkg::sat_coord($signed({{18{cmd_q.coord_y[31]}}, cmd_q.coord_y})
                  + $signed({{2{fut_py[63]}}, fut_py[63:16]}));
        ptr_q  <= '0;
        best_q <= '0;
        walk_q <= 1'b0;
      end
      S_RD_E: begin
        sx_q <= rdata_q[63:32];
        sy_q <= rdata_q[31:0];
      end
      S_RD_X: begin
        ex_q <= rdata_q[63:32];
        ey_q <= rdata_q[31:0];
        dx_q <= $signed({rdata_q[63], rdata_q[63:32]}) - $signed({sx_q[31], sx_q});
        dy_q <= $signed({rdata_q[31], rdata_q[31:0]}) - $signed({sy_q[31], sy_q});
      end
      S_SQA: begin
        acc_q <= {2'b00, sq_prod};
      end
      S_SQB: begin
        acc_q <= dist_n;
        rem_q <= '0;
        len_q <= '0;
        cnt_q <= '0;
      end
      S_SQRT: begin
        acc_q <= {acc_q[63:0], 2'b00};
        rem_q <= rem_n;
        len_q <= root_n;
        cnt_q <= cnt_q + 6'd1;
      end
      S_DXI, S_DYI: begin
        drem_q <= {ppft_pkg::mag33((state_q == S_DXI) ? dx_q : dy_q), 16'h0000};
        dv_q   <= {len_q, 16'h0000};
        cnt_q  <= '0;
      end
      S_DIVX, S_DIVY: begin
        if (dv_ge) drem_q <= drem_q - dv_q[47:0];
        dv_q  <= {1'b0, dv_q[48:1]};
        dq_q  <= dq_n;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd16) begin
          if (state_q == S_DIVX) ux_q <= unit_n;
          else                   uy_q <= unit_n;
        end
      end
      S_PJA: begin
        pacc_q <= 52'(pj_x);
      end
      S_PJB: begin
        proj_q <= pj_sum[51:16];
      end
      S_PTA: begin
        if (proj_q > $signed({3'b000, len_q})) begin
          qx_q <= ex_q;
          qy_q <= ey_q;
        end else if (proj_q[35]) begin
          qx_q <= sx_q;
          qy_q <= sy_q;
        end else begin
          qx_q <= ppft_pkg::sat_coord($signed({{18{sx_q[31]}}, sx_q})
                  + $signed({{14{pt_x[51]}}, pt_x[51:16]}));
        end
      end
      S_PTB: begin
        qy_q <= ppft_pkg::sat_coord($signed({{18{sy_q[31]}}, sy_q})
                + $signed({{14{pt_y[51]}}, pt_y[51:16]}));
      end
      S_DSA: begin
        acc_q <= {2'b00, sq_prod};
      end
      S_DSB: begin
        // Strictly closer replaces, so the earliest segment wins a tie.
        if (ptr_q == '0 || dist_n < best_d_q) begin
          best_d_q <= dist_n;
          best_q   <= ptr_q;
          nx_q     <= qx_q;
          ny_q     <= qy_q;
        end
        if (seg_more) ptr_q <= ptr_q + 6'd1;
      end
      S_WINIT: begin
        sx_q    <= nx_q;
        sy_q    <= ny_q;
        ptr_q   <= best_q;
        total_q <= '0;
        walk_q  <= 1'b1;
      end
      S_WCHK: begin
        if (go_on && seg_more) begin
          total_q <= 31'(total_q + len_q);
          ptr_q   <= ptr_q + 6'd1;
        end
      end
      S_WLASTC: begin
        tx_q <= rdata_q[63:32];
        ty_q <= rdata_q[31:0];
      end
      S_TGA: begin
        tx_q <= ppft_pkg::sat_coord($signed({{18{sx_q[31]}}, sx_q})
                + $signed({{16{tg_x[49]}}, tg_x[49:16]}));
      end
      S_TGB: begin
        ty_q <= ppft_pkg::sat_coord($signed({{18{sy_q[31]}}, sy_q})
                + $signed({{16{tg_y[49]}}, tg_y[49:16]}));
      end
      default: ;
    endcase
  end

  assign res_valid_o           = (state_q == S_DONE);
  assign res_o.target_x        = tx_q;
  assign res_o.target_y        = ty_q;
  assign res_o.nearest_x       = nx_q;
  assign res_o.nearest_y       = ny_q;
  assign res_o.nearest_segment = best_q;
  assign res_o.future_x        = fx_q;
  assign res_o.future_y        = fy_q;

`ifndef SYNTHESIS
  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.opcode == ppft_pkg::OP_QUERY) |=> busy)
    else $error("query transaction did not start the sequencer");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (({1'b0, best_q} + 7'd2) <= n_w))
    else $error("nearest segment beyond the path in use");
`endif

endmodule
